// ----- design/ddo_pkg.sv -----
package ddo_pkg;

  localparam int unsigned COUNT_BITS_DEF   = 32;
  localparam int unsigned CORDIC_STEPS_DEF = 24;
  localparam int unsigned ACC_W            = 48;
  localparam int unsigned CFG_IDX_W        = 2;

  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_SET    = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  // spare code: report the pose, change nothing
  localparam logic [1:0] OP_NOP    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_LEFT_TICK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_TICK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TURNS      = 2'd2;

  localparam logic signed [35:0] CORDIC_GAIN = 36'sh026DD3B6A;

  typedef struct packed {
    logic [1:0]         op;
    logic [31:0]        left_count;
    logic [31:0]        right_count;
    logic signed [31:0] set_x;
    logic signed [31:0] set_y;
    logic signed [31:0] set_heading;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] heading;
    logic               primed;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;    // capture item, run op decode
    logic mul_ds;     // wheel products
    logic mul_turn;   // heading product
    logic cordic_ini;
    logic cordic_step;
    logic mul_xy_lo;
    logic mul_xy_hi;
    logic update;
  } dp_cmd_t;

  typedef struct packed {
    logic is_sample;  // op 0 and primed already
  } dp_sts_t;

  function automatic logic [31:0] atan_turns(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;  5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;  5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;  5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;  5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;  5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;  5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;  5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;  5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;  5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;  5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;  5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;  5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;  default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

// ----- design/ddo_ctrl.sv -----
module ddo_ctrl #(
  parameter int unsigned CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  ddo_pkg::dp_sts_t sts_i,
  output ddo_pkg::dp_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MDS   = 3'd1;
  localparam logic [2:0] S_MTURN = 3'd2;
  localparam logic [2:0] S_CORD  = 3'd3;
  localparam logic [2:0] S_MLO   = 3'd4;
  localparam logic [2:0] S_MHI   = 3'd5;
  localparam logic [2:0] S_UPD   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  localparam int unsigned CW = $clog2(CORDIC_STEPS + 1);

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = S_MDS;
        end
      end
      S_MDS: begin
        if (sts_i.is_sample) begin
          cmd_o.mul_ds = 1'b1;
          state_d = S_MTURN;
        end else begin
          state_d = S_OUT;
        end
      end
      S_MTURN: begin
        cmd_o.mul_turn = 1'b1;
        state_d = S_CORD;
        cnt_d = '0;
      end
      S_CORD: begin
        if (cnt_q == '0) begin
          cmd_o.cordic_ini = 1'b1;
          cnt_d = cnt_q + 1'b1;
        end else begin
          cmd_o.cordic_step = 1'b1;
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == CW'(CORDIC_STEPS)) state_d = S_MLO;
        end
      end
      S_MLO: begin
        cmd_o.mul_xy_lo = 1'b1;
        state_d = S_MHI;
      end
      S_MHI: begin
        cmd_o.mul_xy_hi = 1'b1;
        state_d = S_UPD;
      end
      S_UPD: begin
        cmd_o.update = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CORD) |-> (cnt_q <= CW'(CORDIC_STEPS)))
    else $error("cordic count out of range");
  a_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("ready while result pending");
  a_upd_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.update |=> out_valid_o)
    else $error("update not followed by result");
`endif

endmodule

// ----- design/ddo_datapath.sv -----
module ddo_datapath #(
  parameter int unsigned COUNT_BITS   = ddo_pkg::COUNT_BITS_DEF,
  parameter int unsigned CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ddo_pkg::dp_cmd_t  cmd_i,
  output ddo_pkg::dp_sts_t  sts_o,
  input  ddo_pkg::in_item_t in_i,
  input  logic [31:0]       left_tick_i,
  input  logic [31:0]       right_tick_i,
  input  logic [31:0]       turns_i,
  output ddo_pkg::out_item_t out_o
);

  localparam int unsigned AW = ddo_pkg::ACC_W;
  localparam int unsigned SW = $clog2(CORDIC_STEPS + 1);

  logic [COUNT_BITS-1:0] prev_l_q, prev_r_q;
  logic                  primed_q;
  logic [AW-1:0]         acc_x_q, acc_y_q;
  logic [31:0]           acc_h_q;
  logic                  is_samp_q;
  logic signed [COUNT_BITS-1:0] dl_q, dr_q;
  logic signed [63:0]    dsl_q, dsr_q;
  logic [31:0]           dth_q, half_q;
  logic signed [35:0]    cx_q, cy_q;
  logic signed [32:0]    cz_q;
  logic [SW-1:0]         it_q;
  logic                  flip_q;
  logic signed [63:0]    ds_q;
  logic signed [95:0]    px_q, py_q;

  logic [COUNT_BITS-1:0] lc, rc;
  assign lc = in_i.left_count[COUNT_BITS-1:0];
  assign rc = in_i.right_count[COUNT_BITS-1:0];

  assign sts_o.is_sample = is_samp_q;

  // midpoint heading angle and its half-plane fold
  logic [31:0] ang;
  logic        fl;
  assign ang = acc_h_q + half_q;
  assign fl  = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);

  logic [63:0] ds_sum, pdiff;
  logic [63:0] prod_t;
  logic [63:0] pt_lo;
  logic [16:0] pt_hi;
  assign ds_sum = {dsl_q[63], dsl_q[63:1]} + {dsr_q[63], dsr_q[63:1]}
                  + {63'd0, dsl_q[0] & dsr_q[0]};
  assign pdiff  = 64'(dsr_q - dsl_q);
  // only bits up to 48 of the heading product are kept
  assign pt_lo  = {32'd0, pdiff[31:0]} * {32'd0, turns_i};
  assign pt_hi  = pdiff[48:32] * turns_i[16:0];
  assign prod_t = pt_lo + {15'd0, pt_hi, 32'd0};

  logic signed [35:0] sh_x, sh_y, cc, ss;
  logic [31:0]        at;
  assign sh_x = cx_q >>> it_q;
  assign sh_y = cy_q >>> it_q;
  assign at   = ddo_pkg::atan_turns(5'(it_q));
  assign cc   = flip_q ? -cx_q : cx_q;
  assign ss   = flip_q ? -cy_q : cy_q;

  // ds * trig split into 32-bit halves of ds, low half first, then high half
  logic signed [68:0] plx, ply;
  logic signed [68:0] phx, phy;
  assign plx = $signed({1'b0, ds_q[31:0]}) * cc;
  assign ply = $signed({1'b0, ds_q[31:0]}) * ss;
  assign phx = $signed(ds_q[63:32]) * cc;
  assign phy = $signed(ds_q[63:32]) * ss;

  logic signed [95:0] fx, fy;
  assign fx = px_q >>> 30;
  assign fy = py_q >>> 30;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_l_q  <= '0;
      prev_r_q  <= '0;
      primed_q  <= 1'b0;
      acc_x_q   <= '0;
      acc_y_q   <= '0;
      acc_h_q   <= '0;
      is_samp_q <= 1'b0;
    end else if (cmd_i.load_in) begin
      is_samp_q <= 1'b0;
      case (in_i.op)
        ddo_pkg::OP_SAMPLE: begin
          prev_l_q <= lc;
          prev_r_q <= rc;
          primed_q <= 1'b1;
          is_samp_q <= primed_q;
        end
        ddo_pkg::OP_SET: begin
          acc_x_q <= {in_i.set_x, 16'd0};
          acc_y_q <= {in_i.set_y, 16'd0};
          acc_h_q <= in_i.set_heading;
        end
        ddo_pkg::OP_CLEAR: begin
          acc_x_q  <= '0;
          acc_y_q  <= '0;
          acc_h_q  <= '0;
          primed_q <= 1'b0;
        end
        default: ;
      endcase
    end else if (cmd_i.update) begin
      acc_x_q <= acc_x_q + fx[AW-1:0];
      acc_y_q <= acc_y_q + fy[AW-1:0];
      acc_h_q <= acc_h_q + dth_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      dl_q <= lc - prev_l_q;
      dr_q <= rc - prev_r_q;
    end
    if (cmd_i.mul_ds) begin
      dsl_q <= 64'(dl_q) * $signed({32'd0, left_tick_i});
      dsr_q <= 64'(dr_q) * $signed({32'd0, right_tick_i});
    end
    if (cmd_i.mul_turn) begin
      ds_q   <= ds_sum;
      dth_q  <= prod_t[47:16];
      half_q <= prod_t[48:17];
    end
    if (cmd_i.cordic_ini) begin
      flip_q <= fl;
      cz_q   <= 33'($signed(fl ? ang - 32'h80000000 : ang));
      cx_q   <= ddo_pkg::CORDIC_GAIN;
      cy_q   <= '0;
      it_q   <= '0;
    end
    if (cmd_i.cordic_step) begin
      if (!cz_q[32]) begin
        cx_q <= cx_q - sh_y;
        cy_q <= cy_q + sh_x;
        cz_q <= cz_q - $signed({1'b0, at});
      end else begin
        cx_q <= cx_q + sh_y;
        cy_q <= cy_q - sh_x;
        cz_q <= cz_q + $signed({1'b0, at});
      end
      it_q <= it_q + 1'b1;
    end
    if (cmd_i.mul_xy_lo) begin
      px_q <= 96'(plx);
      py_q <= 96'(ply);
    end
    if (cmd_i.mul_xy_hi) begin
      px_q <= px_q + (96'(phx) <<< 32);
      py_q <= py_q + (96'(phy) <<< 32);
    end
  end

  assign out_o.pos_x   = acc_x_q[47:16];
  assign out_o.pos_y   = acc_y_q[47:16];
  assign out_o.heading = acc_h_q;
  assign out_o.primed  = primed_q;

`ifndef NO_ASSERTIONS
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_in && in_i.op == ddo_pkg::OP_CLEAR) |=> !primed_q)
    else $error("clear left primed set");
  a_prime: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_in && in_i.op == ddo_pkg::OP_SAMPLE) |=> primed_q)
    else $error("sample did not prime");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!cmd_i.load_in && !cmd_i.update) |=> $stable(acc_h_q))
    else $error("heading moved outside update");
`endif

endmodule

// ----- design/differential_drive_odometry.sv -----
// Sequence: op 0 with a stored sample raises the result after the wheel and heading products,
// the CORDIC seed, CORDIC_STEPS rotation steps at one rotation step per cycle, two trig
// products and the update; other ops go from op decode straight to the result.
// Throughput: one item at a time; a new item is accepted only once the result is taken.
// Reset (rst_ni low, asynchronous): pose, stored counts, primed and config registers clear.
module differential_drive_odometry #(
  parameter int unsigned COUNT_BITS   = ddo_pkg::COUNT_BITS_DEF,
  parameter int unsigned CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  ddo_pkg::in_item_t                in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output ddo_pkg::out_item_t               out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ddo_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [31:0]                      cfg_data_i
);

  logic [31:0] ltick_q, rtick_q, turns_q;
  ddo_pkg::dp_cmd_t cmd;
  ddo_pkg::dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ltick_q <= '0;
      rtick_q <= '0;
      turns_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ddo_pkg::REG_LEFT_TICK:  ltick_q <= cfg_data_i;
        ddo_pkg::REG_RIGHT_TICK: rtick_q <= cfg_data_i;
        ddo_pkg::REG_TURNS:      turns_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ddo_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ddo_datapath #(.COUNT_BITS(COUNT_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_i        (in_data_i),
    .left_tick_i (ltick_q),
    .right_tick_i(rtick_q),
    .turns_i     (turns_q),
    .out_o       (out_data_o)
  );

endmodule

// ----- verif/differential_drive_odometry_tb.sv -----
module differential_drive_odometry_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned N_RANDOM = 1700;

  typedef struct {
    ddo_pkg::in_item_t  item;
    logic               check_fixed;
    ddo_pkg::out_item_t fixed;
  } directed_row_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  ddo_pkg::in_item_t             in_data;
  logic                          out_valid;
  logic                          out_ready;
  ddo_pkg::out_item_t            out_data;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [ddo_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [31:0]                   cfg_data;

  logic [31:0] left_tick_q, right_tick_q, turns_q;
  logic [31:0] prev_left_q, prev_right_q;
  logic        primed_q;
  logic [47:0] pose_x_q, pose_y_q;
  logic [31:0] heading_q;

  ddo_pkg::out_item_t pose_queue[$];
  int        n_errors;
  int        send_idle_pct;
  int        recv_idle_pct;
  int        unsigned n_random_sent;

  differential_drive_odometry i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  // floor of v / 2^s
  function automatic logic signed [63:0] floor_shr(logic signed [63:0] v, int s);
    return v >>> s;
  endfunction

  task automatic cordic_sincos(input logic [31:0] angle, output logic signed [63:0] c,
                               output logic signed [63:0] s);
    logic               flip;
    logic [31:0]        a;
    logic signed [63:0] x, y, z, dx, dy;
    flip = (angle[31:30] == 2'd1) || (angle[31:30] == 2'd2);
    a = flip ? angle - 32'h8000_0000 : angle;
    z = {{32{a[31]}}, a};
    x = 64'sh26DD3B6A;
    y = 0;
    for (int i = 0; i < 24; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x = x - dx; y = y + dy;
        z = z - $signed({32'd0, ddo_pkg::atan_turns(i[4:0])});
      end else begin
        x = x + dx; y = y - dy;
        z = z + $signed({32'd0, ddo_pkg::atan_turns(i[4:0])});
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  // low bits of floor(a * b / 2^30), exact
  function automatic logic [47:0] scale_q30(logic [63:0] a, logic signed [63:0] b);
    logic signed [127:0] p;
    p = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
    p = p >>> 30;
    return p[47:0];
  endfunction

  function automatic ddo_pkg::out_item_t pose_now();
    ddo_pkg::out_item_t r;
    r.pos_x   = pose_x_q[47:16];
    r.pos_y   = pose_y_q[47:16];
    r.heading = heading_q;
    r.primed  = primed_q;
    return r;
  endfunction

  task automatic predict_pose(input ddo_pkg::in_item_t it);
    logic [63:0]        dl, dr, ds_l, ds_r, ds, p;
    logic signed [63:0] c, s;
    case (it.op)
      ddo_pkg::OP_SAMPLE: begin
        if (!primed_q) begin
          prev_left_q  = it.left_count;
          prev_right_q = it.right_count;
          primed_q     = 1'b1;
        end else begin
          dl = {{32{1'b0}}, it.left_count - prev_left_q};
          dr = {{32{1'b0}}, it.right_count - prev_right_q};
          dl = {{32{dl[31]}}, dl[31:0]};
          dr = {{32{dr[31]}}, dr[31:0]};
          prev_left_q  = it.left_count;
          prev_right_q = it.right_count;
          ds_l = dl * {32'd0, left_tick_q};
          ds_r = dr * {32'd0, right_tick_q};
          ds = {ds_l[63], ds_l[63:1]} + {ds_r[63], ds_r[63:1]} + {63'd0, ds_l[0] & ds_r[0]};
          p = (ds_r - ds_l) * {32'd0, turns_q};
          cordic_sincos(heading_q + p[48:17], c, s);
          pose_x_q  = pose_x_q + scale_q30(ds, c);
          pose_y_q  = pose_y_q + scale_q30(ds, s);
          heading_q = heading_q + p[47:16];
        end
      end
      ddo_pkg::OP_SET: begin
        pose_x_q  = {it.set_x, 16'd0};
        pose_y_q  = {it.set_y, 16'd0};
        heading_q = it.set_heading;
      end
      ddo_pkg::OP_CLEAR: begin
        pose_x_q  = '0;
        pose_y_q  = '0;
        heading_q = '0;
        primed_q  = 1'b0;
      end
      default: ;
    endcase
    pose_queue.push_back(pose_now());
  endtask

  task automatic send_item(input ddo_pkg::in_item_t it);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(negedge clk);
    in_valid = 1'b1;
    in_data  = it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_pose(it);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_reg(input logic [ddo_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      ddo_pkg::REG_LEFT_TICK:  left_tick_q  = val;
      ddo_pkg::REG_RIGHT_TICK: right_tick_q = val;
      ddo_pkg::REG_TURNS:      turns_q      = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain_poses();
    int guard;
    guard = 0;
    while (pose_queue.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    if (pose_queue.size() != 0) begin
      $display("tb: failure");
      $finish;
    end
    repeat (40) @(negedge clk);
  endtask

  function automatic ddo_pkg::in_item_t random_item();
    ddo_pkg::in_item_t it;
    int unsigned sel;
    it.op          = ddo_pkg::OP_SAMPLE;
    it.left_count  = $urandom;
    it.right_count = $urandom;
    it.set_x       = $urandom;
    it.set_y       = $urandom;
    it.set_heading = $urandom;
    sel = $urandom_range(99);
    if (sel < 80) begin
      // mostly small motion steps around the previous counts
      it.left_count  = prev_left_q + 32'($signed($urandom_range(4000)) - 2000);
      it.right_count = prev_right_q + 32'($signed($urandom_range(4000)) - 2000);
      if ($urandom_range(9) == 0) it.left_count = $urandom;
    end else if (sel < 90) begin
      it.op = ddo_pkg::OP_SET;
    end else if (sel < 95) begin
      it.op = ddo_pkg::OP_CLEAR;
    end else begin
      it.op = ddo_pkg::OP_NOP;
    end
    return it;
  endfunction

  // check each result transfer against the oldest prediction
  always @(posedge clk) begin
    ddo_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pose_queue.size() == 0) begin
        $display("%0t: unexpected result %p", $realtime, out_data);
        n_errors++;
      end else begin
        want = pose_queue.pop_front();
        if (out_data.pos_x !== want.pos_x) begin
          $display("%0t: pos_x exp %h got %h", $realtime, want.pos_x, out_data.pos_x);
          n_errors++;
        end
        if (out_data.pos_y !== want.pos_y) begin
          $display("%0t: pos_y exp %h got %h", $realtime, want.pos_y, out_data.pos_y);
          n_errors++;
        end
        if (out_data.heading !== want.heading) begin
          $display("%0t: heading exp %h got %h", $realtime, want.heading, out_data.heading);
          n_errors++;
        end
        if (out_data.primed !== want.primed) begin
          $display("%0t: primed exp %b got %b", $realtime, want.primed, out_data.primed);
          n_errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    directed_row_t      rows[$];
    directed_row_t      r;
    ddo_pkg::in_item_t  it;
    ddo_pkg::out_item_t zero_pose;
    logic [31:0]        settings[4][3];

    rst_n = 1'b0; in_valid = 1'b0; in_data = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    n_errors = 0; n_random_sent = 0;
    send_idle_pct = 22; recv_idle_pct = 79;
    left_tick_q = 0; right_tick_q = 0; turns_q = 0;
    prev_left_q = 0; prev_right_q = 0; primed_q = 0;
    pose_x_q = 0; pose_y_q = 0; heading_q = 0;
    zero_pose = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // zero registers: no motion on samples, only priming
    it = '0; it.op = ddo_pkg::OP_NOP;
    r.item = it; r.check_fixed = 1; r.fixed = zero_pose; rows.push_back(r);
    it.op = ddo_pkg::OP_SAMPLE; it.left_count = 32'hFFFF_FFFF; it.right_count = 0;
    r.item = it; r.fixed = zero_pose; r.fixed.primed = 1; rows.push_back(r);
    it.left_count = 0; it.right_count = 32'h8000_0000;
    r.item = it; rows.push_back(r);
    foreach (rows[i]) begin
      send_item(rows[i].item);
      if (rows[i].check_fixed && pose_queue[$] !== rows[i].fixed) begin
        $display("%0t: directed row %0d exp %p got %p", $realtime, i, rows[i].fixed,
                 pose_queue[$]);
        n_errors++;
      end
    end
    drain_poses();

    // registers at extremes, then realistic, then partly zero, then small
    settings[0] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
    settings[1] = '{32'h0001_0000, 32'h0001_0200, 32'h0002_8000};
    settings[2] = '{32'h0000_0000, 32'h0004_0000, 32'h0000_0000};
    settings[3] = '{32'h0000_1234, 32'h0000_1200, 32'h0100_0000};

    for (int ph = 0; ph < 4; ph++) begin
      write_reg(ddo_pkg::REG_LEFT_TICK, settings[ph][0]);
      write_reg(ddo_pkg::REG_RIGHT_TICK, settings[ph][1]);
      write_reg(ddo_pkg::REG_TURNS, settings[ph][2]);
      if (ph == 0) begin
        rows.delete();
        r.check_fixed = 0;
        it = '0; it.op = ddo_pkg::OP_CLEAR; r.item = it; rows.push_back(r);
        it.op = ddo_pkg::OP_SAMPLE; r.item = it; rows.push_back(r);
        it.left_count = 32'h8000_0000; it.right_count = 32'h7FFF_FFFF;
        r.item = it; rows.push_back(r);
        it.left_count = 32'hFFFF_FFFF; it.right_count = 32'hFFFF_FFFF;
        r.item = it; rows.push_back(r);
        it.left_count = 0; it.right_count = 0; r.item = it; rows.push_back(r);
        it.op = ddo_pkg::OP_SET; it.set_x = 32'sh7FFF_FFFF; it.set_y = 32'sh8000_0000;
        it.set_heading = 32'sh8000_0000; r.item = it; rows.push_back(r);
        it.op = ddo_pkg::OP_SAMPLE; it.left_count = 5; it.right_count = 3;
        r.item = it; rows.push_back(r);
        it.op = ddo_pkg::OP_SET; it.set_x = 32'sh8000_0000; it.set_y = 32'sh7FFF_FFFF;
        it.set_heading = 32'sh4000_0000; r.item = it; rows.push_back(r);
        it.op = ddo_pkg::OP_SAMPLE; it.left_count = 32'hFFFF_FFF0; it.right_count = 32'h10;
        r.item = it; rows.push_back(r);
        it.op = ddo_pkg::OP_NOP; r.item = it; rows.push_back(r);
        foreach (rows[i]) send_item(rows[i].item);
      end
      for (int k = 0; k < N_RANDOM / 4; k++) begin
        if (n_random_sent == N_RANDOM / 3) begin
          send_idle_pct = 79; recv_idle_pct = 22;
        end else if (n_random_sent == 2 * N_RANDOM / 3) begin
          send_idle_pct = 0; recv_idle_pct = 0;
        end
        send_item(random_item());
        n_random_sent++;
      end
      drain_poses();
    end

    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/ddo_pkg.sv
design/ddo_ctrl.sv
design/ddo_datapath.sv
design/differential_drive_odometry.sv
verif/differential_drive_odometry_tb.sv
